@@ hdl/svm_pkg.sv @@
// shared types, sizes and codes for the stack machine executor
`timescale 1ns / 1ps
`default_nettype none
package svm_pkg;

    localparam int STACK_DEPTH  = 1024;
    localparam int HEAP_DEPTH   = 1024;
    localparam int STATIC_DEPTH = 256;
    localparam int TEMP_DEPTH   = 8;

    // depths are powers of two, so address wrap is a mask
    localparam int STACK_AW  = $clog2(STACK_DEPTH);
    localparam int HEAP_AW   = $clog2(HEAP_DEPTH);
    localparam int STATIC_AW = $clog2(STATIC_DEPTH);
    localparam int TEMP_AW   = $clog2(TEMP_DEPTH);

    localparam int CLR_DEPTH = (STACK_DEPTH > HEAP_DEPTH)
        ? ((STACK_DEPTH > STATIC_DEPTH) ? STACK_DEPTH : STATIC_DEPTH)
        : ((HEAP_DEPTH > STATIC_DEPTH) ? HEAP_DEPTH : STATIC_DEPTH);
    localparam int CLR_AW = $clog2(CLR_DEPTH);

    localparam int DATA_W = 32;
    localparam int IP_W   = 12;
    localparam int FP_W   = 16;
    localparam int PL_W   = 13;
    localparam int STEP_W = 20;
    localparam int IPN_W  = 34;
    localparam int DIV_CW = $clog2(DATA_W);

    localparam int STEP_LIMIT  = 999999;
    localparam int FRAME_WORDS = 5;

    // frame slot order, shared by call (writes) and return (reads)
    localparam logic [2:0] SLOT_RET  = 3'd0;
    localparam logic [2:0] SLOT_LCL  = 3'd1;
    localparam logic [2:0] SLOT_ARG  = 3'd2;
    localparam logic [2:0] SLOT_THIS = 3'd3;
    localparam logic [2:0] SLOT_THAT = 3'd4;
    localparam logic [2:0] SLOT_TOP  = 3'd5;

    typedef enum logic [4:0] {
        OP_PUSH, OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NEG,
        OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR, OP_NOT, OP_OUT, OP_OUTC,
        OP_OUTSTR, OP_OUTSP, OP_OUTNL, OP_GOTO, OP_IFGO, OP_CALL,
        OP_FUNCTION, OP_RETURN, OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        SEG_ARG, SEG_LOCAL, SEG_STATIC, SEG_CONST,
        SEG_THIS, SEG_THAT, SEG_POINTER, SEG_TEMP
    } seg_t;

    typedef enum logic [2:0] {
        KIND_NONE, KIND_INT, KIND_CHAR, KIND_STR, KIND_SPACE, KIND_NL
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_PUSH_WR, ST_OP1, ST_BIN_B,
        ST_BIN_X, ST_DIV, ST_BIN_WR, ST_CALL, ST_RET, ST_RET_WR,
        ST_FINISH, ST_OUT
    } state_t;

endpackage
`default_nettype wire

@@ hdl/svm_div.sv @@
// iterative signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module svm_div
    import svm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   busy,
    output logic [DATA_W-1:0]      quotient,
    output logic [DATA_W-1:0]      remainder
);

    logic              busy_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DATA_W - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg   <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_reg   <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            rem_reg   <= '0;
            neg_q_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_reg <= dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

@@ hdl/stack_vm_instruction_executor_top.sv @@
// stack machine executor: sequencer, stores, frame registers and alu
// throughput: one word at a time, the next word is taken once the result word has left;
// div and mod wait on the iterative divider, call and return go through the frame slots in turn;
// reset: asynchronous, then a clearing pass over CLR_DEPTH addresses (1024 as built) of the
// stack, heap and static memories while input stays stalled
`timescale 1ns / 1ps
`default_nettype none
module stack_vm_instruction_executor_top
    import svm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                cfg_write_en,
    input  wire logic [PL_W-1:0]     cfg_write_data,
    // input words
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [4:0]          op,
    input  wire logic [2:0]          segment,
    input  wire logic signed [31:0]  operand,
    input  wire logic [IP_W-1:0]     target,
    // result words
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [IP_W-1:0]          next_ip,
    output logic                     halted,
    output logic [2:0]               out_kind,
    output logic signed [31:0]       out_value,
    output logic                     div_fault
);

    // sequencer
    state_t state_reg, state_next;

    // latched instruction
    op_t               op_reg;
    seg_t              seg_reg;
    logic [DATA_W-1:0] opnd_reg;
    logic [IP_W-1:0]   tgt_reg;

    // architectural state
    logic [PL_W-1:0]   program_length_reg;
    logic [IP_W-1:0]   instr_ptr_reg;
    logic [FP_W-1:0]   stack_ptr_reg;
    logic [FP_W-1:0]   local_base_reg;
    logic [FP_W-1:0]   arg_base_reg;
    logic [DATA_W-1:0] this_ptr_reg;
    logic [DATA_W-1:0] that_ptr_reg;
    logic [STEP_W-1:0] step_count_reg;
    logic              halt_reg;
    logic [DATA_W-1:0] temp_reg [TEMP_DEPTH];

    // sequencing and scratch
    logic [CLR_AW-1:0]       clr_idx_reg;
    logic [2:0]              cnt_reg;
    logic [DATA_W-1:0]       a_reg;
    logic [DATA_W-1:0]       b_reg;
    logic [FP_W-1:0]         fr_arg_reg;
    logic [FP_W-1:0]         fr_lcl_reg;
    logic signed [IPN_W-1:0] ipn_reg;
    kind_t                   kind_reg;
    logic [DATA_W-1:0]       val_reg;
    logic                    fault_reg;

    // output word
    logic              out_valid_reg;
    logic [IP_W-1:0]   next_ip_reg;
    logic              halted_reg;
    kind_t             out_kind_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              div_fault_reg;

    // memories
    logic [DATA_W-1:0] stk_mem  [STACK_DEPTH];
    logic [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    logic [DATA_W-1:0] stat_mem [STATIC_DEPTH];

    logic                 stk_we;
    logic [STACK_AW-1:0]  stk_waddr;
    logic [DATA_W-1:0]    stk_wdata;
    logic [STACK_AW-1:0]  stk_raddr;
    logic [DATA_W-1:0]    stk_rd_reg;
    logic                 heap_we;
    logic [HEAP_AW-1:0]   heap_waddr;
    logic [DATA_W-1:0]    heap_wdata;
    logic [HEAP_AW-1:0]   heap_addr;
    logic [DATA_W-1:0]    heap_rd_reg;
    logic                 stat_we;
    logic [STATIC_AW-1:0] stat_waddr;
    logic [DATA_W-1:0]    stat_wdata;
    logic [STATIC_AW-1:0] stat_addr;
    logic [DATA_W-1:0]    stat_rd_reg;

    // address and guard helpers
    logic [DATA_W-1:0] arg_sum;
    logic [DATA_W-1:0] lcl_sum;
    logic [DATA_W-1:0] ptr_sum;
    logic [FP_W-1:0]   sp_m1;
    logic [FP_W-1:0]   sp_m2;
    logic [FP_W-1:0]   sp_cnt;
    logic [FP_W-1:0]   lb_cnt;
    logic              is_bin;
    logic              is_divmod;
    logic              has1;
    logic              has2;
    logic              push_ok;
    logic [DATA_W-1:0] push_val;
    logic [DATA_W-1:0] frame_word;
    logic [DATA_W-1:0] alu_res;

    // divider
    logic              div_start;
    logic              div_busy;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] div_rem;

    // end of program and step limit
    logic signed [IPN_W-1:0] pl_m1;
    logic signed [IPN_W-1:0] ipn_p1;
    logic                    reach_end;
    logic [STEP_W-1:0]       step_next;
    logic                    limit_hit;

    assign arg_sum = DATA_W'(arg_base_reg) + opnd_reg;
    assign lcl_sum = DATA_W'(local_base_reg) + opnd_reg;
    assign ptr_sum = ((seg_reg == SEG_THIS) ? this_ptr_reg : that_ptr_reg) + opnd_reg;
    assign sp_m1   = stack_ptr_reg - 1'b1;
    assign sp_m2   = stack_ptr_reg - 2'd2;
    assign sp_cnt  = stack_ptr_reg + FP_W'(cnt_reg);
    assign lb_cnt  = local_base_reg - FP_W'(FRAME_WORDS) + FP_W'(cnt_reg);

    assign is_divmod = (op_reg == OP_DIV) || (op_reg == OP_MOD);
    assign is_bin    = (op_reg == OP_ADD) || (op_reg == OP_SUB) || (op_reg == OP_MUL)
                    || is_divmod || (op_reg == OP_EQ) || (op_reg == OP_GT)
                    || (op_reg == OP_LT) || (op_reg == OP_AND) || (op_reg == OP_OR);
    assign has1    = (stack_ptr_reg != '0);
    assign has2    = (stack_ptr_reg > FP_W'(1));
    assign push_ok = ({1'b0, stack_ptr_reg} < (FP_W + 1)'(STACK_DEPTH - 1));

    assign heap_addr = ptr_sum[HEAP_AW-1:0];
    assign stat_addr = opnd_reg[STATIC_AW-1:0];

    // value a push places on the stack, from the read made in decode
    always_comb
    begin
        unique case (seg_reg)
            SEG_ARG, SEG_LOCAL: push_val = stk_rd_reg;
            SEG_STATIC:         push_val = stat_rd_reg;
            SEG_CONST:          push_val = opnd_reg;
            SEG_THIS, SEG_THAT: push_val = heap_rd_reg;
            SEG_POINTER:        push_val = (opnd_reg == '0) ? this_ptr_reg : that_ptr_reg;
            default:            push_val = temp_reg[opnd_reg[TEMP_AW-1:0]];
        endcase
    end

    // call frame word for the current slot
    always_comb
    begin
        unique case (cnt_reg)
            SLOT_RET:  frame_word = DATA_W'(instr_ptr_reg) + 1'b1;
            SLOT_LCL:  frame_word = DATA_W'(local_base_reg);
            SLOT_ARG:  frame_word = DATA_W'(arg_base_reg);
            SLOT_THIS: frame_word = this_ptr_reg;
            default:   frame_word = that_ptr_reg;
        endcase
    end

    // shared alu: operands a (below top) and b (top)
    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  alu_res = a_reg + b_reg;
            OP_SUB:  alu_res = a_reg - b_reg;
            OP_MUL:  alu_res = DATA_W'(a_reg * b_reg);
            OP_DIV:  alu_res = fault_reg ? '0 : div_quo;
            OP_MOD:  alu_res = fault_reg ? '0 : div_rem;
            OP_EQ:   alu_res = DATA_W'(a_reg == b_reg);
            OP_GT:   alu_res = DATA_W'($signed(a_reg) > $signed(b_reg));
            OP_LT:   alu_res = DATA_W'($signed(a_reg) < $signed(b_reg));
            OP_AND:  alu_res = DATA_W'((a_reg != '0) && (b_reg != '0));
            default: alu_res = DATA_W'((a_reg != '0) || (b_reg != '0));
        endcase
    end

    assign div_start = (state_reg == ST_BIN_X) && is_divmod && (stk_rd_reg != '0);

    svm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (stk_rd_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == CLR_AW'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (halt_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    unique case (op_reg)
                        OP_PUSH:   state_next = push_ok ? ST_PUSH_WR : ST_FINISH;
                        OP_POP, OP_NEG, OP_NOT, OP_OUT, OP_OUTC, OP_IFGO:
                                   state_next = has1 ? ST_OP1 : ST_FINISH;
                        OP_CALL:   state_next = ST_CALL;
                        OP_RETURN: state_next = ST_RET;
                        default:   state_next = (is_bin && has2) ? ST_BIN_B : ST_FINISH;
                    endcase
                end
            end
            ST_PUSH_WR: state_next = ST_FINISH;
            ST_OP1:     state_next = ST_FINISH;
            ST_BIN_B:   state_next = ST_BIN_X;
            ST_BIN_X:   state_next = div_start ? ST_DIV : ST_BIN_WR;
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_BIN_WR;
                end
            end
            ST_BIN_WR:  state_next = ST_FINISH;
            ST_CALL:
            begin
                if (cnt_reg == SLOT_THAT)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RET:
            begin
                if (cnt_reg == SLOT_TOP + 1'b1)
                begin
                    state_next = ST_RET_WR;
                end
            end
            ST_RET_WR:  state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = sp_m1[STACK_AW-1:0];
        heap_we    = 1'b0;
        heap_waddr = heap_addr;
        heap_wdata = stk_rd_reg;
        stat_we    = 1'b0;
        stat_waddr = stat_addr;
        stat_wdata = stk_rd_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // entry 0 of the stack holds its depth after reset
                stk_we     = ({1'b0, clr_idx_reg} < (CLR_AW + 1)'(STACK_DEPTH));
                stk_waddr  = clr_idx_reg[STACK_AW-1:0];
                stk_wdata  = (clr_idx_reg == '0) ? DATA_W'(STACK_DEPTH) : '0;
                heap_we    = ({1'b0, clr_idx_reg} < (CLR_AW + 1)'(HEAP_DEPTH));
                heap_waddr = clr_idx_reg[HEAP_AW-1:0];
                heap_wdata = '0;
                stat_we    = ({1'b0, clr_idx_reg} < (CLR_AW + 1)'(STATIC_DEPTH));
                stat_waddr = clr_idx_reg[STATIC_AW-1:0];
                stat_wdata = '0;
            end
            ST_DECODE:
            begin
                if (op_reg == OP_PUSH)
                begin
                    stk_raddr = (seg_reg == SEG_ARG) ? arg_sum[STACK_AW-1:0]
                                                     : lcl_sum[STACK_AW-1:0];
                end
                else if (is_bin)
                begin
                    stk_raddr = sp_m2[STACK_AW-1:0];
                end
            end
            ST_PUSH_WR:
            begin
                stk_we    = 1'b1;
                stk_waddr = stack_ptr_reg[STACK_AW-1:0];
                stk_wdata = push_val;
            end
            ST_OP1:
            begin
                if (op_reg == OP_POP)
                begin
                    stk_wdata = stk_rd_reg;
                    unique case (seg_reg)
                        SEG_ARG:
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = arg_sum[STACK_AW-1:0];
                        end
                        SEG_LOCAL:
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = lcl_sum[STACK_AW-1:0];
                        end
                        SEG_STATIC:         stat_we = 1'b1;
                        SEG_THIS, SEG_THAT: heap_we = 1'b1;
                        default:            stk_we  = 1'b0;
                    endcase
                end
                else if ((op_reg == OP_NEG) || (op_reg == OP_NOT))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_m1[STACK_AW-1:0];
                    stk_wdata = (op_reg == OP_NEG) ? (~stk_rd_reg + 1'b1)
                                                   : DATA_W'(stk_rd_reg == '0);
                end
            end
            ST_BIN_WR:
            begin
                stk_we    = 1'b1;
                stk_waddr = sp_m2[STACK_AW-1:0];
                stk_wdata = alu_res;
            end
            ST_CALL:
            begin
                stk_we    = 1'b1;
                stk_waddr = sp_cnt[STACK_AW-1:0];
                stk_wdata = frame_word;
            end
            ST_RET:
            begin
                // frame slots sit just below the local base, top of stack last
                stk_raddr = (cnt_reg == SLOT_TOP) ? sp_m1[STACK_AW-1:0]
                                                  : lb_cnt[STACK_AW-1:0];
            end
            ST_RET_WR:
            begin
                stk_we    = 1'b1;
                stk_waddr = arg_base_reg[STACK_AW-1:0];
                stk_wdata = b_reg;
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd_reg <= heap_mem[heap_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_waddr] <= stat_wdata;
        end
        stat_rd_reg <= stat_mem[stat_addr];
    end

    // halt decision on the index reached
    assign pl_m1     = $signed({{(IPN_W - PL_W){1'b0}}, program_length_reg}) - 2'sd1;
    assign ipn_p1    = ipn_reg + 2'sd1;
    assign reach_end = (ipn_reg >= pl_m1);
    assign step_next = step_count_reg + 1'b1;
    assign limit_hit = (step_next >= STEP_W'(STEP_LIMIT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // architectural and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg <= PL_W'(1);
            instr_ptr_reg      <= '0;
            stack_ptr_reg      <= FP_W'(FRAME_WORDS);
            local_base_reg     <= FP_W'(FRAME_WORDS);
            arg_base_reg       <= '0;
            this_ptr_reg       <= '0;
            that_ptr_reg       <= '0;
            step_count_reg     <= '0;
            halt_reg           <= 1'b0;
            clr_idx_reg        <= '0;
            cnt_reg            <= '0;
            out_valid_reg      <= 1'b0;
            for (int i = 0; i < TEMP_DEPTH; i++)
            begin
                temp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                program_length_reg <= cfg_write_data;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
                ST_DECODE:
                begin
                    cnt_reg <= '0;
                    if (!halt_reg && (op_reg == OP_FUNCTION))
                    begin
                        stack_ptr_reg <= stack_ptr_reg + opnd_reg[FP_W-1:0];
                    end
                end
                ST_PUSH_WR:
                begin
                    stack_ptr_reg <= stack_ptr_reg + 1'b1;
                end
                ST_OP1:
                begin
                    if ((op_reg != OP_NEG) && (op_reg != OP_NOT))
                    begin
                        stack_ptr_reg <= sp_m1;
                    end
                    if (op_reg == OP_POP)
                    begin
                        if (seg_reg == SEG_POINTER)
                        begin
                            if (opnd_reg == '0)
                            begin
                                this_ptr_reg <= stk_rd_reg;
                            end
                            else
                            begin
                                that_ptr_reg <= stk_rd_reg;
                            end
                        end
                        else if (seg_reg == SEG_TEMP)
                        begin
                            temp_reg[opnd_reg[TEMP_AW-1:0]] <= stk_rd_reg;
                        end
                    end
                end
                ST_BIN_WR:
                begin
                    stack_ptr_reg <= sp_m1;
                end
                ST_CALL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SLOT_THAT)
                    begin
                        arg_base_reg   <= stack_ptr_reg - opnd_reg[FP_W-1:0];
                        local_base_reg <= stack_ptr_reg + FP_W'(FRAME_WORDS);
                        stack_ptr_reg  <= stack_ptr_reg + FP_W'(FRAME_WORDS);
                    end
                end
                ST_RET:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SLOT_THIS + 1'b1)
                    begin
                        this_ptr_reg <= stk_rd_reg;
                    end
                    if (cnt_reg == SLOT_THAT + 1'b1)
                    begin
                        that_ptr_reg <= stk_rd_reg;
                    end
                end
                ST_RET_WR:
                begin
                    stack_ptr_reg  <= arg_base_reg + 1'b1;
                    arg_base_reg   <= fr_arg_reg;
                    local_base_reg <= fr_lcl_reg;
                end
                ST_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    if (!halt_reg)
                    begin
                        step_count_reg <= step_next;
                        halt_reg       <= reach_end || limit_hit;
                        instr_ptr_reg  <= reach_end ? ipn_reg[IP_W-1:0] : ipn_p1[IP_W-1:0];
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // instruction latch, scratch and output word
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            op_reg   <= op_t'(op);
            seg_reg  <= seg_t'(segment);
            opnd_reg <= operand;
            tgt_reg  <= target;
        end
        unique case (state_reg)
            ST_DECODE:
            begin
                fault_reg <= 1'b0;
                kind_reg  <= KIND_NONE;
                val_reg   <= '0;
                ipn_reg   <= $signed(IPN_W'(instr_ptr_reg));
                unique case (op_reg)
                    OP_OUTSTR:
                    begin
                        kind_reg <= KIND_STR;
                        val_reg  <= DATA_W'(tgt_reg);
                    end
                    OP_OUTSP:  kind_reg <= KIND_SPACE;
                    OP_OUTNL:  kind_reg <= KIND_NL;
                    OP_GOTO:   ipn_reg  <= $signed(IPN_W'(tgt_reg));
                    OP_CALL:   ipn_reg  <= $signed(IPN_W'(tgt_reg)) - 2'sd1;
                    default:   kind_reg <= KIND_NONE;
                endcase
            end
            ST_OP1:
            begin
                if (op_reg == OP_OUT)
                begin
                    kind_reg <= KIND_INT;
                    val_reg  <= stk_rd_reg;
                end
                else if (op_reg == OP_OUTC)
                begin
                    kind_reg <= KIND_CHAR;
                    val_reg  <= {{(DATA_W - 8){1'b0}}, stk_rd_reg[7:0]};
                end
                else if ((op_reg == OP_IFGO) && (stk_rd_reg != '0))
                begin
                    ipn_reg <= $signed(IPN_W'(tgt_reg));
                end
            end
            ST_BIN_B:
            begin
                a_reg <= stk_rd_reg;
            end
            ST_BIN_X:
            begin
                b_reg     <= stk_rd_reg;
                fault_reg <= is_divmod && (stk_rd_reg == '0);
            end
            ST_RET:
            begin
                if (cnt_reg == SLOT_RET + 1'b1)
                begin
                    a_reg <= stk_rd_reg;
                end
                if (cnt_reg == SLOT_LCL + 1'b1)
                begin
                    fr_lcl_reg <= stk_rd_reg[FP_W-1:0];
                end
                if (cnt_reg == SLOT_ARG + 1'b1)
                begin
                    fr_arg_reg <= stk_rd_reg[FP_W-1:0];
                end
                if (cnt_reg == SLOT_TOP + 1'b1)
                begin
                    b_reg <= stk_rd_reg;
                end
            end
            ST_RET_WR:
            begin
                // return address word is signed; continue after the call site
                ipn_reg <= IPN_W'($signed(a_reg)) - 2'sd1;
            end
            ST_FINISH:
            begin
                if (halt_reg)
                begin
                    next_ip_reg   <= instr_ptr_reg;
                    halted_reg    <= 1'b1;
                    out_kind_reg  <= KIND_NONE;
                    out_value_reg <= '0;
                    div_fault_reg <= 1'b0;
                end
                else
                begin
                    next_ip_reg   <= reach_end ? ipn_reg[IP_W-1:0] : ipn_p1[IP_W-1:0];
                    halted_reg    <= reach_end || limit_hit;
                    out_kind_reg  <= kind_reg;
                    out_value_reg <= val_reg;
                    div_fault_reg <= fault_reg;
                end
            end
            default:
            begin
                fault_reg <= fault_reg;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign next_ip   = next_ip_reg;
    assign halted    = halted_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign div_fault = div_fault_reg;

`ifndef SYNTHESIS
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> out_valid_reg)
        else $error("result word not raised after finish");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halt_reg) |-> halt_reg)
        else $error("halt cleared without reset");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
// self-checking testbench for the stack machine executor
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import svm_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;  // clearing pass, long hold-off and divider all fit
    localparam int SETTLE_CYCLES  = 60;    // longest word (div) plus margin
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [4:0]  op;
        logic [2:0]  seg;
        logic [31:0] opnd;
        logic [11:0] tgt;
    } vm_word_t;

    typedef struct packed {
        logic [11:0] nip;
        logic        halt;
        logic [2:0]  kind;
        logic [31:0] val;
        logic        fault;
    } vm_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [PL_W-1:0]     cfg_write_data;
    logic                in_valid;
    logic                in_stall;
    logic [4:0]          op;
    logic [2:0]          segment;
    logic signed [31:0]  operand;
    logic [IP_W-1:0]     target;
    logic                out_valid;
    logic                out_stall;
    logic [IP_W-1:0]     next_ip;
    logic                halted;
    logic [2:0]          out_kind;
    logic signed [31:0]  out_value;
    logic                div_fault;

    // machine state as the executor should hold it
    logic [31:0] m_stack [STACK_DEPTH];
    logic [31:0] m_heap [HEAP_DEPTH];
    logic [31:0] m_static [STATIC_DEPTH];
    logic [31:0] m_temp [TEMP_DEPTH];
    logic [11:0] m_ip;
    logic [15:0] m_sp, m_lcl, m_arg;
    logic [31:0] m_this, m_that;
    int unsigned m_steps;
    logic [12:0] m_plen;
    logic        m_halt;

    vm_result_t expected_results[$];
    int         errors;
    int         quiet_cycles;
    bit         tx_idle_on;
    bit         rx_idle_on;
    bit         hold_req;
    int         call_depth;

    stack_vm_instruction_executor_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .segment        (segment),
        .operand        (operand),
        .target         (target),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .next_ip        (next_ip),
        .halted         (halted),
        .out_kind       (out_kind),
        .out_value      (out_value),
        .div_fault      (div_fault)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // stack address wrap
    function automatic logic [STACK_AW-1:0] saddr(input logic [31:0] x);
        return x[STACK_AW-1:0];
    endfunction

    // 16-bit frame arithmetic, wrapping
    function automatic logic [15:0] fadd(input logic [15:0] x, input logic [15:0] y);
        return x + y;
    endfunction

    // index the word lands on (jump target or current ip), without touching state
    function automatic longint landing_index(input vm_word_t w);
        longint ipn;
        ipn = longint'(m_ip);
        case (w.op)
            OP_GOTO:   ipn = longint'(w.tgt);
            OP_IFGO:   if (m_sp >= 1 && m_stack[saddr(m_sp - 16'd1)] != 0) ipn = longint'(w.tgt);
            OP_CALL:   ipn = longint'(w.tgt) - 1;
            OP_RETURN: ipn = longint'($signed(m_stack[saddr(fadd(m_lcl, -16'sd5))])) - 1;
            default:   ;
        endcase
        return ipn;
    endfunction

    // execute one word against the machine state and give the result it must report
    function automatic vm_result_t vm_execute(input vm_word_t w);
        vm_result_t r;
        logic [15:0] sp, lb, at;
        logic [31:0] a, b, v, res, ret;
        longint ipn, q;
        r   = '0;
        sp  = m_sp;
        ipn = longint'(m_ip);
        if (m_halt)
        begin
            r.nip  = m_ip;
            r.halt = 1'b1;
            return r;
        end
        case (w.op)
            OP_PUSH:
                if (sp < STACK_DEPTH - 1)
                begin
                    case (w.seg)
                        SEG_ARG:     v = m_stack[saddr(m_arg + w.opnd)];
                        SEG_LOCAL:   v = m_stack[saddr(m_lcl + w.opnd)];
                        SEG_STATIC:  v = m_static[w.opnd[STATIC_AW-1:0]];
                        SEG_CONST:   v = w.opnd;
                        SEG_THIS:    v = m_heap[(m_this + w.opnd) % HEAP_DEPTH];
                        SEG_THAT:    v = m_heap[(m_that + w.opnd) % HEAP_DEPTH];
                        SEG_POINTER: v = (w.opnd == 0) ? m_this : m_that;
                        default:     v = m_temp[w.opnd[TEMP_AW-1:0]];
                    endcase
                    m_stack[saddr(sp)] = v;
                    sp = sp + 16'd1;
                end
            OP_POP:
                if (sp >= 1)
                begin
                    v = m_stack[saddr(sp - 16'd1)];
                    case (w.seg)
                        SEG_ARG:     m_stack[saddr(m_arg + w.opnd)] = v;
                        SEG_LOCAL:   m_stack[saddr(m_lcl + w.opnd)] = v;
                        SEG_STATIC:  m_static[w.opnd[STATIC_AW-1:0]] = v;
                        SEG_CONST:   ;
                        SEG_THIS:    m_heap[(m_this + w.opnd) % HEAP_DEPTH] = v;
                        SEG_THAT:    m_heap[(m_that + w.opnd) % HEAP_DEPTH] = v;
                        SEG_POINTER: if (w.opnd == 0) m_this = v; else m_that = v;
                        default:     m_temp[w.opnd[TEMP_AW-1:0]] = v;
                    endcase
                    sp = sp - 16'd1;
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR:
                if (sp >= 2)
                begin
                    a = m_stack[saddr(sp - 16'd2)];
                    b = m_stack[saddr(sp - 16'd1)];
                    case (w.op)
                        OP_ADD: res = a + b;
                        OP_SUB: res = a - b;
                        OP_MUL: res = a * b;
                        OP_DIV, OP_MOD:
                            if (b == 0)
                            begin
                                res     = '0;
                                r.fault = 1'b1;
                            end
                            else
                            begin
                                // 64-bit so the most negative over minus one stays defined
                                if (w.op == OP_DIV)
                                    q = longint'($signed(a)) / longint'($signed(b));
                                else
                                    q = longint'($signed(a)) % longint'($signed(b));
                                res = q[31:0];
                            end
                        OP_EQ:  res = {31'b0, a == b};
                        OP_GT:  res = {31'b0, $signed(a) > $signed(b)};
                        OP_LT:  res = {31'b0, $signed(a) < $signed(b)};
                        OP_AND: res = {31'b0, (a != 0) && (b != 0)};
                        default: res = {31'b0, (a != 0) || (b != 0)};
                    endcase
                    m_stack[saddr(sp - 16'd2)] = res;
                    sp = sp - 16'd1;
                end
            OP_NEG, OP_NOT:
                if (sp >= 1)
                begin
                    a = m_stack[saddr(sp - 16'd1)];
                    m_stack[saddr(sp - 16'd1)] = (w.op == OP_NEG) ? -a : {31'b0, a == 0};
                end
            OP_OUT, OP_OUTC:
                if (sp >= 1)
                begin
                    a      = m_stack[saddr(sp - 16'd1)];
                    r.kind = (w.op == OP_OUT) ? KIND_INT : KIND_CHAR;
                    r.val  = (w.op == OP_OUT) ? a : {24'b0, a[7:0]};
                    sp     = sp - 16'd1;
                end
            OP_OUTSTR:
            begin
                r.kind = KIND_STR;
                r.val  = {20'b0, w.tgt};
            end
            OP_OUTSP: r.kind = KIND_SPACE;
            OP_OUTNL: r.kind = KIND_NL;
            OP_GOTO:  ipn = longint'(w.tgt);
            OP_IFGO:
                if (sp >= 1)
                begin
                    if (m_stack[saddr(sp - 16'd1)] != 0) ipn = longint'(w.tgt);
                    sp = sp - 16'd1;
                end
            OP_CALL:
            begin
                m_stack[saddr(sp)]                 = {20'b0, m_ip} + 32'd1;
                m_stack[saddr(fadd(sp, 16'd1))]    = {16'b0, m_lcl};
                m_stack[saddr(fadd(sp, 16'd2))]    = {16'b0, m_arg};
                m_stack[saddr(fadd(sp, 16'd3))]    = m_this;
                m_stack[saddr(fadd(sp, 16'd4))]    = m_that;
                v     = {16'b0, sp} - w.opnd;
                m_arg = v[15:0];
                m_lcl = fadd(sp, 16'd5);
                sp    = fadd(sp, 16'd5);
                ipn   = longint'(w.tgt) - 1;
            end
            OP_FUNCTION: sp = sp + w.opnd[15:0];
            OP_RETURN:
            begin
                lb     = m_lcl;
                at     = m_arg;
                ret    = m_stack[saddr(fadd(lb, -16'sd5))];
                m_that = m_stack[saddr(fadd(lb, -16'sd1))];
                m_this = m_stack[saddr(fadd(lb, -16'sd2))];
                v      = m_stack[saddr(fadd(lb, -16'sd3))];
                m_arg  = v[15:0];
                v      = m_stack[saddr(fadd(lb, -16'sd4))];
                m_lcl  = v[15:0];
                m_stack[saddr(at)] = m_stack[saddr(sp - 16'd1)];
                sp     = at + 16'd1;
                ipn    = longint'($signed(ret)) - 1;
            end
            default: ;  // nop and unused opcodes
        endcase
        m_sp    = sp;
        m_steps = m_steps + 1;
        if (ipn >= longint'(m_plen) - 1)
        begin
            m_halt = 1'b1;
            q      = ipn;
        end
        else
            q = ipn + 1;
        m_ip = q[11:0];
        if (m_steps >= STEP_LIMIT) m_halt = 1'b1;
        r.nip  = m_ip;
        r.halt = m_halt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // shared driving and checking
    // ------------------------------------------------------------------

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // drive one word; called and returning at a falling edge
    task automatic put_word(input vm_word_t w);
        if (tx_idle_on && $urandom_range(99) < 34)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        op       = w.op;
        segment  = w.seg;
        operand  = w.opnd;
        target   = w.tgt;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(vm_execute(w));
        @(negedge clk);
    endtask

    task automatic issue(input op_t o, input seg_t s, input logic [31:0] v,
                         input logic [11:0] t);
        vm_word_t w;
        w.op   = o;
        w.seg  = s;
        w.opnd = v;
        w.tgt  = t;
        put_word(w);
    endtask

    // drop valid, wait for all results and let the datapath settle
    task automatic drain();
        in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_plen(input logic [12:0] value);
        drain();
        cfg_write_en   = 1'b1;
        cfg_write_data = value;
        @(negedge clk);
        cfg_write_en   = 1'b0;
        m_plen         = value;
    endtask

    // result checking, oldest expectation first
    always @(posedge clk)
    begin
        vm_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result word, next_ip %0h at %0t", next_ip, $realtime);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (next_ip !== want.nip)     report("next_ip", next_ip, want.nip);
                if (halted !== want.halt)     report("halted", halted, want.halt);
                if (out_kind !== want.kind)   report("out_kind", out_kind, want.kind);
                if (out_value !== want.val)   report("out_value", out_value, want.val);
                if (div_fault !== want.fault) report("div_fault", div_fault, want.fault);
            end
        end
    end

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_stall = rx_idle_on && ($urandom_range(99) < 34);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extreme constants, division corner cases and the pointer, argument and that segments
    task automatic test_arith_edges();
        issue(OP_PUSH, SEG_CONST, 32'h8000_0000, '0);
        issue(OP_PUSH, SEG_CONST, 32'hFFFF_FFFF, '0);
        issue(OP_DIV, SEG_CONST, '0, '0);                 // most negative over minus one
        issue(OP_PUSH, SEG_CONST, 32'hFFFF_FFFF, '0);
        issue(OP_MOD, SEG_CONST, '0, '0);
        issue(OP_PUSH, SEG_CONST, 32'h7FFF_FFFF, '0);
        issue(OP_PUSH, SEG_CONST, '0, '0);
        issue(OP_DIV, SEG_CONST, '0, '0);                 // zero divisor
        issue(OP_PUSH, SEG_CONST, '0, '0);
        issue(OP_MOD, SEG_CONST, '0, '0);
        issue(OP_POP, SEG_POINTER, 32'd7, '0);            // that
        issue(OP_PUSH, SEG_CONST, 32'd300, '0);
        issue(OP_POP, SEG_POINTER, '0, '0);               // this
        issue(OP_PUSH, SEG_ARG, '0, '0);                  // entry 0 holds the depth
        issue(OP_POP, SEG_THAT, 32'hFFFF_FFFF, '0);
        issue(OP_PUSH, SEG_POINTER, 32'd1, '0);
        issue(OP_OUTC, SEG_CONST, '0, '0);
        issue(OP_OUTSTR, SEG_CONST, '0, 12'hFFF);
    endtask

    // guards on an empty and a full stack, and unused opcodes
    task automatic test_guards();
        issue(OP_FUNCTION, SEG_CONST, -32'(m_sp), '0);    // empty the stack
        issue(OP_POP, SEG_TEMP, '0, '0);
        issue(OP_ADD, SEG_CONST, '0, '0);
        issue(OP_NEG, SEG_CONST, '0, '0);
        issue(OP_OUT, SEG_CONST, '0, '0);
        issue(OP_IFGO, SEG_CONST, '0, 12'd5);
        issue(OP_FUNCTION, SEG_CONST, 32'd1023, '0);      // full stack
        issue(OP_PUSH, SEG_CONST, 32'd1, '0);
        issue(OP_FUNCTION, SEG_CONST, -32'sd1013, '0);
        put_word('{op: 5'd25, seg: SEG_CONST, opnd: '0, tgt: '0});
        put_word('{op: 5'd31, seg: SEG_TEMP, opnd: '1, tgt: '1});
    endtask

    // well-formed call, function and return with a taken jump on the way
    task automatic test_call_return();
        issue(OP_PUSH, SEG_CONST, 32'd9, '0);
        issue(OP_CALL, SEG_CONST, 32'd1, 12'd200);
        issue(OP_FUNCTION, SEG_CONST, 32'd2, '0);
        issue(OP_PUSH, SEG_ARG, '0, '0);
        issue(OP_IFGO, SEG_CONST, '0, 12'd210);
        issue(OP_PUSH, SEG_CONST, 32'd3, '0);
        issue(OP_RETURN, SEG_CONST, '0, '0);
        issue(OP_GOTO, SEG_CONST, '0, 12'd4094);          // then wraps to zero
        issue(OP_NOP, SEG_CONST, '0, '0);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    // mostly stack-shaped programs with random content, some noise
    function automatic vm_word_t pick_word();
        vm_word_t w;
        int dice;
        w.seg  = seg_t'($urandom_range(7));
        w.opnd = pick_operand();
        w.tgt  = $urandom_range(4095);
        dice   = $urandom_range(99);
        if (m_sp > 700)
        begin
            w.op   = OP_FUNCTION;
            w.opnd = -32'(m_sp) + 32'($urandom_range(2, 20));
        end
        else if (dice < 30) w.op = OP_PUSH;
        else if (dice < 42) w.op = OP_POP;
        else if (dice < 62) w.op = 5'($urandom_range(OP_ADD, OP_OR));
        else if (dice < 67) w.op = $urandom_range(1) ? OP_NEG : OP_NOT;
        else if (dice < 75) w.op = 5'($urandom_range(OP_OUT, OP_OUTNL));
        else if (dice < 83) w.op = $urandom_range(1) ? OP_GOTO : OP_IFGO;
        else if (dice < 88) w.op = OP_CALL;
        else if (dice < 91)
        begin
            w.op   = OP_FUNCTION;
            w.opnd = $urandom_range(0, 4);
        end
        else if (dice < 97) w.op = (call_depth > 0 || dice == 96) ? OP_RETURN : OP_NOP;
        else w.op = 5'($urandom_range(OP_NOP, 31));
        if (w.op == OP_CALL) w.opnd = $urandom_range(0, 3);
        // never let a random word stop the machine
        if (landing_index(w) >= longint'(m_plen) - 1)
        begin
            w.op  = OP_GOTO;
            w.tgt = $urandom_range(0, (m_plen - 2 > 4095) ? 4095 : m_plen - 2);
        end
        if (w.op == OP_CALL && call_depth < 8) call_depth++;
        if (w.op == OP_RETURN && call_depth > 0) call_depth--;
        return w;
    endfunction

    task automatic test_random(input int count);
        repeat (count) put_word(pick_word());
    endtask

    // receiver holds off while words keep coming
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        repeat (12) put_word(pick_word());
        tx_idle_on = 1'b1;
        drain();
    endtask

    // a jump to the last index stops the machine for good
    task automatic test_halt();
        write_plen(13'd4096);
        issue(OP_GOTO, SEG_CONST, '0, 12'd4095);
        issue(OP_PUSH, SEG_CONST, 32'd1, '0);
        write_plen(13'd1);
        issue(OP_NOP, SEG_CONST, '0, '0);
        issue(OP_OUTNL, SEG_CONST, '0, '0);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        op             = '0;
        segment        = '0;
        operand        = '0;
        target         = '0;
        out_stall      = 1'b0;
        hold_req       = 1'b0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        errors         = 0;
        quiet_cycles   = 0;
        call_depth     = 0;
        foreach (m_stack[i]) m_stack[i] = '0;
        foreach (m_heap[i]) m_heap[i] = '0;
        foreach (m_static[i]) m_static[i] = '0;
        foreach (m_temp[i]) m_temp[i] = '0;
        m_stack[0] = STACK_DEPTH;
        m_ip       = '0;
        m_sp       = 16'd5;
        m_lcl      = 16'd5;
        m_arg      = '0;
        m_this     = '0;
        m_that     = '0;
        m_steps    = 0;
        m_plen     = 13'd1;
        m_halt     = 1'b0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        write_plen(13'h1FFF);
        test_arith_edges();
        test_guards();
        test_call_return();
        test_random(300);
        test_backpressure();

        // long run with neither side idling
        write_plen(13'd4096);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random(250);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // sender waits for every result before going on
        drain();
        write_plen(13'd300);
        test_random(300);
        write_plen(13'd2);
        test_random(20);
        write_plen(13'h1FFF);
        test_random(250);

        test_halt();
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

@@ stack_vm_instruction_executor_top.f @@
hdl/svm_pkg.sv
hdl/svm_div.sv
hdl/stack_vm_instruction_executor_top.sv
dv/tb.sv
